### rtl/core/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
package rar_pkg;
    localparam int WORD_W = 64;
    localparam int DEN_W  = 62;
    localparam int CNT_W  = 7;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_INC = 2'd3;

    typedef logic [WORD_W-1:0] word_t;
endpackage

### rtl/core/rar_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, 64-bit product.
module rar_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rar_pkg::word_t mcand,
    input  rar_pkg::word_t mplier,
    output logic          done,
    output rar_pkg::word_t prod
);
    import rar_pkg::*;

    word_t            mc_reg, mc_next;
    word_t            mp_reg, mp_next;
    word_t            acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    word_t            acc_step;

    // accumulator after the current multiplier bit
    assign acc_step = mp_reg[0] ? acc_reg + mc_reg : acc_reg;

    always_comb
    begin
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            mc_next   = mcand;
            mp_next   = mplier;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_step;
            mc_next  = {mc_reg[WORD_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[WORD_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W-1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    // done on the last bit; product includes that bit
    assign done = busy_reg && (cnt_reg == CNT_W'(WORD_W-1));
    assign prod = acc_step;
endmodule

### rtl/core/rar_gcd.sv
// Binary gcd, one subtract or shift step per cycle.
module rar_gcd (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rar_pkg::word_t x,
    input  rar_pkg::word_t y,
    output logic           done,
    output rar_pkg::word_t g
);
    import rar_pkg::*;

    word_t            u_reg, u_next;
    word_t            v_reg, v_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;

    always_comb
    begin
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        if (start)
        begin
            u_next    = x;
            v_next    = y;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg == '0)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!u_reg[0])
                u_next = u_reg >> 1;
            else if (!v_reg[0])
                v_next = v_reg >> 1;
            else if (u_reg > v_reg)
            begin
                u_next = v_reg;
                v_next = (u_reg - v_reg) >> 1;
            end
            else
                v_next = (v_reg - u_reg) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
    end

    // final shift applied by one barrel shift, k below 64
    assign done = fin_reg;
    assign g    = u_reg << k_reg[5:0];
endmodule

### rtl/core/rar_div.sv
// Restoring divider, one quotient bit per cycle.
module rar_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rar_pkg::word_t dividend,
    input  rar_pkg::word_t divisor,
    output logic           done,
    output rar_pkg::word_t quot
);
    import rar_pkg::*;

    word_t            q_reg, q_next;
    word_t            r_reg, r_next;
    word_t            d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [WORD_W:0]  trial;
    word_t            q_step, r_step;

    assign trial  = {r_reg, q_reg[WORD_W-1]} - {1'b0, d_reg};
    assign q_step = {q_reg[WORD_W-2:0], !trial[WORD_W]};
    assign r_step = trial[WORD_W] ? {r_reg[WORD_W-2:0], q_reg[WORD_W-1]}
                                  : trial[WORD_W-1:0];

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = r_step;
            q_next   = q_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W-1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // done on the last bit; quotient includes that bit
    assign done = busy_reg && (cnt_reg == CNT_W'(WORD_W-1));
    assign quot = q_step;
endmodule

### rtl/core/rational_arith_reduce_unit.sv
// Top level: sequenced rational arithmetic with gcd reduction.
// Sequence: increment goes straight to the output; add/sub starts from S_PRE and runs
// three serial multiplies (two for multiply), then the binary gcd and the two
// divides; a zero numerator or denominator skips the gcd and the divides.
// Throughput: one request at a time; the next is taken once the result leaves.
// Reset (rst_n, async, active low) returns the sequencer to idle, output empty.
module rational_arith_reduce_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic signed [31:0] a_num,
    input  logic [30:0]      a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0]      b_den,
    output logic             out_valid,
    input  logic             out_ready,
    output logic signed [63:0] res_num,
    output logic [61:0]      res_den
);
    import rar_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;  // an*bd
    localparam logic [3:0] S_M2   = 4'd2;  // bn*ad, or an*bn for multiply
    localparam logic [3:0] S_M3   = 4'd3;  // ad*bd
    localparam logic [3:0] S_GCD  = 4'd4;
    localparam logic [3:0] S_D1   = 4'd5;
    localparam logic [3:0] S_D2   = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;
    localparam logic [3:0] S_PRE  = 4'd8;  // start first multiply

    logic [3:0] st_reg, st_next;
    op_t        op_reg;
    word_t      an_reg, ad_reg, bn_reg, bd_reg;
    word_t      x_reg, n_reg, d_reg, mag_reg, g_reg;
    logic       neg_reg;
    logic signed [63:0] rn_reg;
    logic [DEN_W-1:0] rd_reg;

    word_t  an_ext, bn_ext, ad_ext, bd_ext;
    logic   mul_start, gcd_start, div_start;
    word_t  mul_a, mul_b, div_n, div_d;
    logic   mul_done, gcd_done, div_done;
    word_t  prod, gval, quot;
    word_t  sum, nmag;

    // operand unpack: sign-extend numerators, mask denominators
    assign an_ext = word_t'(signed'(a_num[OPERAND_WIDTH-1:0]));
    assign bn_ext = word_t'(signed'(b_num[OPERAND_WIDTH-1:0]));
    assign ad_ext = word_t'(a_den[OPERAND_WIDTH-2:0]);
    assign bd_ext = word_t'(b_den[OPERAND_WIDTH-2:0]);

    assign in_ready  = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign res_num   = rn_reg;
    assign res_den   = rd_reg;

    assign sum  = (op_reg == OP_SUB) ? x_reg - prod : x_reg + prod;
    assign nmag = n_reg[WORD_W-1] ? word_t'(0) - n_reg : n_reg;

    // first divide starts as the gcd lands; the second uses the held copy
    assign div_d = (st_reg == S_GCD) ? gval : g_reg;

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = an_reg;
        mul_b     = bd_reg;
        gcd_start = 1'b0;
        div_start = 1'b0;
        div_n     = mag_reg;
        st_next   = st_reg;
        case (st_reg)
            S_IDLE:
                if (in_valid)
                    st_next = (req_type == OP_INC) ? S_OUT : S_PRE;
            S_PRE:
            begin
                mul_start = 1'b1;
                mul_b     = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                st_next   = (op_reg == OP_MUL) ? S_M2 : S_M1;
            end
            S_M1:
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = bn_reg;
                    mul_b     = ad_reg;
                    st_next   = S_M2;
                end
            S_M2:
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = ad_reg;
                    mul_b     = bd_reg;
                    st_next   = S_M3;
                end
            S_M3:
                if (mul_done)
                begin
                    if (nmag == '0 || prod == '0)
                        st_next = S_OUT;
                    else
                    begin
                        gcd_start = 1'b1;
                        st_next   = S_GCD;
                    end
                end
            S_GCD:
                if (gcd_done)
                begin
                    div_start = 1'b1;
                    st_next   = S_D1;
                end
            S_D1:
                if (div_done)
                begin
                    div_start = 1'b1;
                    div_n     = d_reg;
                    st_next   = S_D2;
                end
            S_D2:
                if (div_done)
                    st_next = S_OUT;
            S_OUT:
                if (out_ready)
                    st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid)
        begin
            op_reg <= req_type;
            an_reg <= an_ext;
            bn_reg <= bn_ext;
            ad_reg <= ad_ext;
            bd_reg <= bd_ext;
            rn_reg <= an_ext + ad_ext;
            rd_reg <= ad_ext[61:0];
        end
        // first product: numerator term x, for add/sub only; multiply's numerator lands in n
        if (st_reg == S_M1 && mul_done)
            x_reg <= prod;
        if (st_reg == S_M2 && mul_done)
            n_reg <= (op_reg == OP_MUL) ? prod : sum;
        if (st_reg == S_M3 && mul_done)
        begin
            d_reg   <= prod;
            mag_reg <= nmag;
            neg_reg <= n_reg[WORD_W-1];
            rn_reg  <= n_reg;
            rd_reg  <= prod[61:0];
        end
        if (st_reg == S_GCD && gcd_done)
            g_reg <= gval;
        if (st_reg == S_D1 && div_done)
            rn_reg <= neg_reg ? word_t'(0) - quot : quot;
        if (st_reg == S_D2 && div_done)
            rd_reg <= quot[61:0];
    end

    rar_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (prod)
    );

    rar_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (nmag),
        .y     (prod),
        .done  (gcd_done),
        .g     (gval)
    );

    rar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (quot)
    );
endmodule

### tb/rational_arith_reduce_unit_test.sv
// Self-checking testbench for the rational arithmetic reduce unit.
`timescale 1ns / 100ps

module rational_arith_reduce_unit_test;
    import rar_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic signed [31:0] a_num;
    logic [30:0] a_den;
    logic signed [31:0] b_num;
    logic [30:0] b_den;
    logic        out_valid;
    logic        out_ready;
    logic signed [63:0] res_num;
    logic [61:0] res_den;

    typedef struct packed {
        logic [63:0] num;
        logic [61:0] den;
    } frac_t;

    frac_t       expected_q[$];
    int          err_count;
    int          idle_pct_in;
    int          idle_pct_out;
    bit          hold_out;
    int          quiet_cycles;

    rational_arith_reduce_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .a_num(a_num), .a_den(a_den),
        .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact rational result; increment is left unreduced, as is a zero numerator or denominator.
    function automatic frac_t rational_result(op_t op, logic signed [31:0] an_in,
            logic [30:0] ad_in, logic signed [31:0] bn_in, logic [30:0] bd_in);
        logic [63:0] an, bn, ad, bd, n, d, mag, g;
        frac_t r;
        an = {{32{an_in[31]}}, an_in};
        bn = {{32{bn_in[31]}}, bn_in};
        ad = {33'd0, ad_in};
        bd = {33'd0, bd_in};
        if (op == OP_INC)
        begin
            n = an + ad;
            d = ad;
        end
        else
        begin
            d = ad * bd;
            if (op == OP_MUL)
                n = an * bn;
            else if (op == OP_ADD)
                n = an * bd + bn * ad;
            else
                n = an * bd - bn * ad;
            mag = n[63] ? -n : n;
            if (mag != 0 && d != 0)
            begin
                g = gcd64(mag, d);
                mag = mag / g;
                d = d / g;
                n = n[63] ? -mag : mag;
            end
        end
        r.num = n;
        r.den = d[61:0];
        return r;
    endfunction

    // Drive one request and wait for its acceptance; valid drops only while idling.
    task automatic send_request(op_t op, logic [31:0] an, logic [30:0] ad,
            logic [31:0] bn, logic [30:0] bd);
        while ($urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(rational_result(op, an, ad, bn, bd));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    function automatic logic [30:0] rand_den();
        case ($urandom_range(3))
            0: return 31'($urandom_range(1, 16));
            1: return 31'h7fffffff - 31'($urandom_range(0, 3));
            default: return 31'($urandom_range(1, 32'h7fffffff));
        endcase
    endfunction

    function automatic logic [31:0] rand_num();
        case ($urandom_range(4))
            0: return 32'($signed($urandom_range(0, 40)) - 20);
            1: return 32'h80000000 + $urandom_range(0, 2);
            2: return 32'h7fffffff - $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        op_t op;
        for (int k = 0; k < 4; k++)
        begin
            op = op_t'(k);
            send_request(op, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7fffffff);
            send_request(op, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1);
            send_request(op, 32'h80000000, 31'd1, 32'h7fffffff, 31'h7fffffff);
            send_request(op, 32'd0, 31'd6, 32'd0, 31'd4);
        end
    endtask

    task automatic test_special();
        send_request(OP_SUB, 32'd3, 31'd4, 32'd3, 31'd4);      // zero numerator
        send_request(OP_MUL, 32'd0, 31'd7, 32'd5, 31'd9);
        send_request(OP_INC, 32'd6, 31'd3, 32'd1, 31'd1);      // no reduction
        send_request(OP_INC, -32'sd4, 31'd4, 32'd0, 31'd2);
        send_request(OP_ADD, 32'd1, 31'd6, 32'd1, 31'd3);
        send_request(OP_MUL, -32'sd4, 31'd6, 32'd9, 31'd2);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            send_request(op_t'($urandom_range(3)), rand_num(), rand_den(),
                         rand_num(), rand_den());
    endtask

    // Receiver holds off long enough for the unit to stall its input.
    task automatic test_backpressure();
        hold_out = 1'b1;
        fork
            test_random(4);
            begin
                repeat (2000) @(posedge clk);
                hold_out = 1'b0;
            end
        join
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_out && ($urandom_range(99) >= idle_pct_out);
    end

    // Result checker.
    always @(posedge clk)
    begin
        frac_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %0d/%0d", $time, res_num, res_den);
                err_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_num !== e.num)
                begin
                    $display("%0t: res_num expected %0d actual %0d",
                             $time, $signed(e.num), res_num);
                    err_count++;
                end
                if (res_den !== e.den)
                begin
                    $display("%0t: res_den expected %0d actual %0d",
                             $time, e.den, res_den);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request or result, outside a receiver hold.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_out)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        err_count    = 0;
        quiet_cycles = 0;
        hold_out     = 1'b0;
        idle_pct_in  = 32;
        idle_pct_out = 32;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = OP_ADD;
        a_num    = '0;
        a_den    = 31'd1;
        b_num    = '0;
        b_den    = 31'd1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_special();
        test_backpressure();
        idle_pct_in  = 0;
        idle_pct_out = 0;
        test_random(120);
        idle_pct_in  = 32;
        idle_pct_out = 32;
        test_random(400);
        wait_drained();
        repeat (600) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
